>>> rtl/prdg_pkg.sv
`default_nettype none
package prdg_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int FRAC_BITS = 16;
    localparam int OUT_FRAC  = 16;

    // The largest normalized magnitude lands in [2^29, 2^30).
    localparam int NORM_BITS = 30;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TAN    = 2'd2;
    localparam logic [1:0] REG_ASPECT = 2'd3;

    typedef struct packed {
        logic ok;
        logic xneg;
        logic yneg;
    } t_flags;

endpackage
`default_nettype wire

>>> rtl/prdg_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// The high part of the numerator must be below the divisor.
module prdg_div #(
    parameter int QW = 24,
    parameter int DW = 13,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_hi,
    input  wire logic [QW-1:0] i_lo,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quot,
    output logic [DW-1:0]      o_rem,
    output logic [SW-1:0]      o_side
);

    logic          w_v    [QW+1];
    logic [DW-1:0] w_rem  [QW+1];
    logic [QW-1:0] w_lo   [QW+1];
    logic [DW-1:0] w_den  [QW+1];
    logic [SW-1:0] w_side [QW+1];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = i_hi;
    assign w_lo[0]   = i_lo;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          r_v;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_lo;
        logic [DW-1:0] r_den;
        logic [SW-1:0] r_side;
        logic [DW:0]   n_trial;
        logic [DW:0]   n_diff;
        logic          n_ge;

        assign n_trial = {w_rem[s], w_lo[s][QW-1]};
        assign n_diff  = n_trial - {1'b0, w_den[s]};
        assign n_ge    = n_trial >= {1'b0, w_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_lo   <= {w_lo[s][QW-2:0], n_ge};
            r_den  <= w_den[s];
            r_side <= w_side[s];
        end

        assign w_v[s+1]    = r_v;
        assign w_rem[s+1]  = r_rem;
        assign w_lo[s+1]   = r_lo;
        assign w_den[s+1]  = r_den;
        assign w_side[s+1] = r_side;
    end

    assign o_valid = w_v[QW];
    assign o_quot  = w_lo[QW];
    assign o_rem   = w_rem[QW];
    assign o_side  = w_side[QW];

endmodule
`default_nettype wire

>>> rtl/primary_ray_direction_generator_core.sv
`default_nettype none
// Pinhole camera primary ray generator. A pixel index is taken whenever start is high;
// busy never rises, so one request is accepted every cycle. Each request yields one
// result, shown for a single cycle with o_valid, after a chain of bit-serial pipelines
// (24 stages for the row/column split, 33 for the scaled x and y, 31 for the square
// root of the length and 17 for the final normalizing divides) plus ten stages of
// multiply, shift and select logic. The results cannot be held off. The user must write
// registers through the APB port only while no request is in flight; the block itself
// does not enforce this.
module primary_ray_direction_generator_core
    import prdg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [23:0] i_pixel_index,
    output logic             o_valid,
    output logic [17:0]      o_dir_x,
    output logic [17:0]      o_dir_y,
    output logic [16:0]      o_dir_z,
    output logic             o_ray_valid,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SQ_STAGES = NORM_BITS + 1;

    // Configuration registers.
    logic [12:0] r_width, r_height;
    logic [23:0] r_tan, r_aspect;
    logic [32:0] r_ta;
    logic [47:0] n_ta_prod;
    logic        n_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign n_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd640;
            r_height <= 13'd480;
            r_tan    <= 24'd65536;
            r_aspect <= 24'd65536;
        end else if (n_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[12:0];
                REG_HEIGHT: r_height <= pwdata[12:0];
                REG_TAN:    r_tan    <= pwdata[23:0];
                REG_ASPECT: r_aspect <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {19'd0, r_width};
            REG_HEIGHT: prdata = {19'd0, r_height};
            REG_TAN:    prdata = {8'd0, r_tan};
            REG_ASPECT: prdata = {8'd0, r_aspect};
            default:    prdata = 32'd0;
        endcase
    end

    // The scaled tangent only depends on registers, so it is kept up to date here.
    assign n_ta_prod = r_tan * r_aspect;
    always_ff @(posedge i_clk) begin
        r_ta <= 33'((49'(n_ta_prod) + 49'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    end

    // Stage A: capture the request and check the range.
    logic        r_a_valid;
    logic [23:0] r_a_idx;
    logic [25:0] n_area;
    logic        n_a_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else          r_a_valid <= start & ~busy;
    end
    always_ff @(posedge i_clk) begin
        r_a_idx <= i_pixel_index;
    end

    assign n_area = r_width * r_height;
    assign n_a_ok = (r_width != 13'd0) && (r_height != 13'd0) &&
                    (r_width <= 13'(MAX_DIM)) && (r_height <= 13'(MAX_DIM)) &&
                    (26'(r_a_idx) < n_area);

    // Row and column.
    logic        w_rc_valid;
    logic [23:0] w_row;
    logic [12:0] w_col;
    logic        w_rc_ok;

    prdg_div #(.QW(24), .DW(13), .SW(1)) u_div_rc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .i_hi    (13'd0),
        .i_lo    (r_a_idx),
        .i_den   (r_width),
        .i_side  (n_a_ok),
        .o_valid (w_rc_valid),
        .o_quot  (w_row),
        .o_rem   (w_col),
        .o_side  (w_rc_ok)
    );

    // Stage C: signed offsets from the image center.
    logic        r_c_valid;
    t_flags      r_c_flags;
    logic [11:0] r_c_xmag, r_c_ymag;
    logic [13:0] n_c2;
    logic [24:0] n_r2;
    logic        n_xneg, n_yneg;
    logic [13:0] n_xd;
    logic [24:0] n_yd;

    assign n_c2   = {w_col, 1'b1};
    assign n_r2   = {w_row, 1'b1};
    assign n_xneg = n_c2 < {1'b0, r_width};
    assign n_yneg = n_r2 > {12'd0, r_height};
    assign n_xd   = n_xneg ? ({1'b0, r_width} - n_c2) : (n_c2 - {1'b0, r_width});
    assign n_yd   = n_yneg ? (n_r2 - {12'd0, r_height}) : ({12'd0, r_height} - n_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_valid <= 1'b0;
        else          r_c_valid <= w_rc_valid;
    end
    always_ff @(posedge i_clk) begin
        r_c_flags <= '{ok: w_rc_ok, xneg: n_xneg, yneg: n_yneg};
        r_c_xmag  <= n_xd[11:0];
        r_c_ymag  <= n_yd[11:0];
    end

    // Stage D: numerators of the rounded x and y scaling.
    logic        r_d_valid;
    t_flags      r_d_flags;
    logic [45:0] r_d_xnum, r_d_ynum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_valid <= 1'b0;
        else          r_d_valid <= r_c_valid;
    end
    always_ff @(posedge i_clk) begin
        r_d_flags <= r_c_flags;
        r_d_xnum  <= 46'(r_c_xmag * r_tan) + 46'(r_width >> 1);
        r_d_ynum  <= 46'(r_c_ymag * r_ta) + 46'(r_height >> 1);
    end

    logic        w_x_valid, w_y_valid;
    logic [32:0] w_xm, w_ym;
    logic        w_x_side;
    logic [1:0]  w_y_side;

    prdg_div #(.QW(33), .DW(13), .SW(1)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_valid),
        .i_hi    (r_d_xnum[45:33]),
        .i_lo    (r_d_xnum[32:0]),
        .i_den   (r_width),
        .i_side  (r_d_flags.xneg),
        .o_valid (w_x_valid),
        .o_quot  (w_xm),
        .o_rem   (),
        .o_side  (w_x_side)
    );

    prdg_div #(.QW(33), .DW(13), .SW(2)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_valid),
        .i_hi    (r_d_ynum[45:33]),
        .i_lo    (r_d_ynum[32:0]),
        .i_den   (r_height),
        .i_side  ({r_d_flags.ok, r_d_flags.yneg}),
        .o_valid (w_y_valid),
        .o_quot  (w_ym),
        .o_rem   (),
        .o_side  (w_y_side)
    );

    // Stage E: largest magnitude, with z fixed at one.
    logic        r_e_valid;
    t_flags      r_e_flags;
    logic [32:0] r_e_xm, r_e_ym, r_e_m;
    logic [32:0] n_m;

    always_comb begin
        n_m = 33'(1 << FRAC_BITS);
        if (w_xm > n_m) n_m = w_xm;
        if (w_ym > n_m) n_m = w_ym;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_valid <= 1'b0;
        else          r_e_valid <= w_y_valid;
    end
    always_ff @(posedge i_clk) begin
        r_e_flags <= '{ok: w_y_side[1], xneg: w_x_side, yneg: w_y_side[0]};
        r_e_xm    <= w_xm;
        r_e_ym    <= w_ym;
        r_e_m     <= n_m;
    end

    // Stage F: bit length of the largest magnitude.
    logic        r_f_valid;
    t_flags      r_f_flags;
    logic [32:0] r_f_xm, r_f_ym;
    logic [5:0]  r_f_lb;
    logic [5:0]  n_lb;

    always_comb begin
        n_lb = 6'd0;
        for (int i = 0; i < 33; i++) begin
            if (r_e_m[i]) n_lb = 6'(i + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_valid <= 1'b0;
        else          r_f_valid <= r_e_valid;
    end
    always_ff @(posedge i_clk) begin
        r_f_flags <= r_e_flags;
        r_f_xm    <= r_e_xm;
        r_f_ym    <= r_e_ym;
        r_f_lb    <= n_lb;
    end

    // Stage G: common shift into the normalized window.
    logic                 r_g_valid;
    t_flags               r_g_flags;
    logic [NORM_BITS-1:0] r_g_x, r_g_y, r_g_z;
    logic [32:0]          n_gx, n_gy, n_gz;

    always_comb begin
        if (r_f_lb > 6'(NORM_BITS)) begin
            n_gx = r_f_xm >> (r_f_lb - 6'(NORM_BITS));
            n_gy = r_f_ym >> (r_f_lb - 6'(NORM_BITS));
            n_gz = 33'(1 << FRAC_BITS) >> (r_f_lb - 6'(NORM_BITS));
        end else begin
            n_gx = r_f_xm << (6'(NORM_BITS) - r_f_lb);
            n_gy = r_f_ym << (6'(NORM_BITS) - r_f_lb);
            n_gz = 33'(1 << FRAC_BITS) << (6'(NORM_BITS) - r_f_lb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_valid <= 1'b0;
        else          r_g_valid <= r_f_valid;
    end
    always_ff @(posedge i_clk) begin
        r_g_flags <= r_f_flags;
        r_g_x     <= n_gx[NORM_BITS-1:0];
        r_g_y     <= n_gy[NORM_BITS-1:0];
        r_g_z     <= n_gz[NORM_BITS-1:0];
    end

    // Stage H: squares. Stage I: their sum.
    logic                 r_h_valid, r_i_valid;
    t_flags               r_h_flags, r_i_flags;
    logic [NORM_BITS-1:0] r_h_x, r_h_y, r_h_z;
    logic [NORM_BITS-1:0] r_i_x, r_i_y, r_i_z;
    logic [59:0]          r_h_xx, r_h_yy, r_h_zz;
    logic [61:0]          r_i_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else begin
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        r_h_flags <= r_g_flags;
        r_h_x     <= r_g_x;
        r_h_y     <= r_g_y;
        r_h_z     <= r_g_z;
        r_h_xx    <= r_g_x * r_g_x;
        r_h_yy    <= r_g_y * r_g_y;
        r_h_zz    <= r_g_z * r_g_z;
        r_i_flags <= r_h_flags;
        r_i_x     <= r_h_x;
        r_i_y     <= r_h_y;
        r_i_z     <= r_h_z;
        r_i_sum   <= 62'(r_h_xx) + 62'(r_h_yy) + 62'(r_h_zz);
    end

    // Square root, one result bit per stage from the top.
    logic                 w_sq_v    [SQ_STAGES+1];
    t_flags               w_sq_f    [SQ_STAGES+1];
    logic [NORM_BITS-1:0] w_sq_x    [SQ_STAGES+1];
    logic [NORM_BITS-1:0] w_sq_y    [SQ_STAGES+1];
    logic [NORM_BITS-1:0] w_sq_z    [SQ_STAGES+1];
    logic [61:0]          w_sq_rem  [SQ_STAGES+1];
    logic [30:0]          w_sq_root [SQ_STAGES+1];

    assign w_sq_v[0]    = r_i_valid;
    assign w_sq_f[0]    = r_i_flags;
    assign w_sq_x[0]    = r_i_x;
    assign w_sq_y[0]    = r_i_y;
    assign w_sq_z[0]    = r_i_z;
    assign w_sq_rem[0]  = r_i_sum;
    assign w_sq_root[0] = 31'd0;

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
        localparam int K = SQ_STAGES - 1 - s;
        logic                 r_v;
        t_flags               r_f;
        logic [NORM_BITS-1:0] r_x, r_y, r_z;
        logic [61:0]          r_rem;
        logic [30:0]          r_root;
        logic [61:0]          n_trial;
        logic                 n_take;

        assign n_trial = (62'(w_sq_root[s]) << (K + 1)) | (62'(1) << (2 * K));
        assign n_take  = w_sq_rem[s] >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v <= 1'b0;
            else          r_v <= w_sq_v[s];
        end
        always_ff @(posedge i_clk) begin
            r_f    <= w_sq_f[s];
            r_x    <= w_sq_x[s];
            r_y    <= w_sq_y[s];
            r_z    <= w_sq_z[s];
            r_rem  <= n_take ? (w_sq_rem[s] - n_trial) : w_sq_rem[s];
            r_root <= n_take ? (w_sq_root[s] | (31'(1) << K)) : w_sq_root[s];
        end

        assign w_sq_v[s+1]    = r_v;
        assign w_sq_f[s+1]    = r_f;
        assign w_sq_x[s+1]    = r_x;
        assign w_sq_y[s+1]    = r_y;
        assign w_sq_z[s+1]    = r_z;
        assign w_sq_rem[s+1]  = r_rem;
        assign w_sq_root[s+1] = r_root;
    end

    // Stage J: rounded numerators for the unit vector.
    logic        r_j_valid;
    t_flags      r_j_flags;
    logic [47:0] r_j_nx, r_j_ny, r_j_nz;
    logic [30:0] r_j_len;
    logic [47:0] n_half;

    assign n_half = 48'(w_sq_root[SQ_STAGES] >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_j_valid <= 1'b0;
        else          r_j_valid <= w_sq_v[SQ_STAGES];
    end
    always_ff @(posedge i_clk) begin
        r_j_flags <= w_sq_f[SQ_STAGES];
        r_j_len   <= w_sq_root[SQ_STAGES];
        r_j_nx    <= (48'(w_sq_x[SQ_STAGES]) << OUT_FRAC) + n_half;
        r_j_ny    <= (48'(w_sq_y[SQ_STAGES]) << OUT_FRAC) + n_half;
        r_j_nz    <= (48'(w_sq_z[SQ_STAGES]) << OUT_FRAC) + n_half;
    end

    logic        w_dx_valid, w_dy_valid, w_dz_valid;
    logic [16:0] w_qx, w_qy, w_qz;
    t_flags      w_dx_flags;
    logic        w_dy_ok, w_dz_ok;

    prdg_div #(.QW(17), .DW(31), .SW($bits(t_flags))) u_div_dx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_j_valid),
        .i_hi    (r_j_nx[47:17]),
        .i_lo    (r_j_nx[16:0]),
        .i_den   (r_j_len),
        .i_side  (r_j_flags),
        .o_valid (w_dx_valid),
        .o_quot  (w_qx),
        .o_rem   (),
        .o_side  (w_dx_flags)
    );

    prdg_div #(.QW(17), .DW(31), .SW(1)) u_div_dy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_j_valid),
        .i_hi    (r_j_ny[47:17]),
        .i_lo    (r_j_ny[16:0]),
        .i_den   (r_j_len),
        .i_side  (r_j_flags.ok),
        .o_valid (w_dy_valid),
        .o_quot  (w_qy),
        .o_rem   (),
        .o_side  (w_dy_ok)
    );

    prdg_div #(.QW(17), .DW(31), .SW(1)) u_div_dz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_j_valid),
        .i_hi    (r_j_nz[47:17]),
        .i_lo    (r_j_nz[16:0]),
        .i_den   (r_j_len),
        .i_side  (r_j_flags.ok),
        .o_valid (w_dz_valid),
        .o_quot  (w_qz),
        .o_rem   (),
        .o_side  (w_dz_ok)
    );

    // Output register: sign reapplied, invalid rays forced to zero.
    logic        r_o_valid, r_o_ray_valid;
    logic [17:0] r_o_x, r_o_y;
    logic [16:0] r_o_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else          r_o_valid <= w_dx_valid;
    end
    always_ff @(posedge i_clk) begin
        r_o_ray_valid <= w_dx_flags.ok;
        if (w_dx_flags.ok) begin
            r_o_x <= w_dx_flags.xneg ? (18'd0 - {1'b0, w_qx}) : {1'b0, w_qx};
            r_o_y <= w_dx_flags.yneg ? (18'd0 - {1'b0, w_qy}) : {1'b0, w_qy};
            r_o_z <= w_qz;
        end else begin
            r_o_x <= 18'd0;
            r_o_y <= 18'd0;
            r_o_z <= 17'd0;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_ray_valid = r_o_ray_valid & r_o_valid;
    assign o_dir_x     = r_o_x;
    assign o_dir_y     = r_o_y;
    assign o_dir_z     = r_o_z;

`ifndef SYNTH
    a_xy_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_x_valid == w_y_valid)
        else $error("x and y divider pipelines out of step");

    a_dir_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dx_valid == w_dy_valid) && (w_dx_valid == w_dz_valid))
        else $error("final divider pipelines out of step");

    a_flag_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dx_valid |-> (w_dy_ok == w_dx_flags.ok) && (w_dz_ok == w_dx_flags.ok))
        else $error("validity flag differs between final dividers");

    a_z_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ray_valid) |-> (o_dir_z != 17'd0))
        else $error("valid ray with zero z component");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ray_valid) |->
            (o_dir_x == 18'd0) && (o_dir_y == 18'd0) && (o_dir_z == 17'd0))
        else $error("invalid ray with nonzero components");
`endif

endmodule
`default_nettype wire
